/* rtl/scp_pkg.sv */
// Types and fixed-point constants shared by the sine/cosine polynomial core.
`timescale 1ns / 1ps
`default_nettype none

package scp_pkg;

    // Quadrant index, reduced angle / polynomial word, wide product.
    typedef logic signed [17:0] q_t;
    typedef logic signed [33:0] t_t;
    typedef logic signed [67:0] prod_t;
    typedef logic signed [47:0] red_t;

    // Per-request sideband carried alongside the polynomial stages.
    typedef struct packed {
        logic odd;   // quadrant odd: cosine polynomial
        logic neg;   // quadrant bit 1: flip the sign
        t_t   t;     // reduced angle, Q.30
        t_t   t2;    // t squared, Q.30
    } side_t;

    // 2/pi in Q.32, pi/2 split as hi (Q.44, in two limbs) and lo (Q.76).
    localparam logic signed [32:0] TWO_OVER_PI = 33'sh0A2F9836E;
    localparam logic signed [25:0] PIO2_HI_H   = 26'sh1921FB;
    localparam logic signed [24:0] PIO2_HI_L   = 25'sh54442D;
    localparam logic signed [29:0] PIO2_LO     = 30'sh18469899;

    // Cosine polynomial, Q.30.
    localparam t_t KC3 = -34'sd1460921;
    localparam t_t KC2 = 34'sd44728461;
    localparam t_t KC1 = 34'sd536869705;
    localparam t_t KC0 = 34'sd1073741803;
    // Sine polynomial, Q.30.
    localparam t_t KS3 = -34'sd209210;
    localparam t_t KS2 = 34'sd8946198;
    localparam t_t KS1 = 34'sd178956710;
    localparam t_t KS0 = 34'sd1073741813;

    // Round a Q.60 product back to Q.30, ties up.
    function automatic t_t rnd_q30(input prod_t v);
        prod_t s;
        s = v + 68'sd536870912;
        return t_t'(s >>> 30);
    endfunction

endpackage

`default_nettype wire

/* rtl/sine_cosine_polynomial_core.sv */
// Top level: pipelined sine/cosine by quadrant reduction and minimax polynomials.
`timescale 1ns / 1ps
`default_nettype none

// Sine/cosine core. Each request carries an angle in radians (signed,
// ANGLE_FRAC_BITS fraction bits) and a cmd bit (0 sine, 1 cosine); each
// result is the value in signed fixed point with RESULT_FRAC_BITS fraction
// bits, saturated to +/-1.0. The core is a 16-stage pipeline: one request
// is taken every clock cycle while s_ready is high. The multipliers (angle
// times 2/pi, quadrant times pi/2, t squared, three Horner steps and the
// final sine step) each own a stage. Every stage carries its own valid bit
// and advances whenever the next stage can take its content, so an output
// stall only backs up occupied stages and bubbles are squeezed out.
// Results come back in request order.
module sine_cosine_polynomial_core #(
    parameter int ANGLE_FRAC_BITS  = 24,
    parameter int RESULT_FRAC_BITS = 30
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire                s_cmd,
    input  wire signed [31:0]  s_angle,
    output logic               m_valid,
    input  wire                m_ready,
    output logic signed [31:0] m_value
);

    localparam int NSTG = 16;
    // Shift from the input format up to Q.44, and down to Q.16.
    localparam int XSH  = 44 - ANGLE_FRAC_BITS;
    localparam int X16SH = ANGLE_FRAC_BITS - 16;
    // Final rounding from Q.30 to the result format.
    localparam int RSH  = 30 - RESULT_FRAC_BITS;
    localparam logic signed [34:0] RHALF   = (35'sd1 <<< RSH) >>> 1;
    localparam logic signed [34:0] LIM     = 35'sd1 <<< RESULT_FRAC_BITS;
    localparam logic signed [31:0] OUT_MAX = 32'(LIM);
    localparam logic signed [64:0] Q_HALF  = 65'sd1 <<< 47;
    localparam logic signed [47:0] LO_HALF = 48'sd1 <<< 31;
    localparam logic signed [47:0] T_HALF  = 48'sd1 <<< 13;
    localparam scp_pkg::t_t        T_BOUND = 34'sh0FFFFFFFF;

    // Valid bit per stage and the per-stage advance chain.
    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] adv;

    always_comb begin
        adv[NSTG-1] = !valid_reg[NSTG-1] || m_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign s_ready = adv[0];
    assign m_valid = valid_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (adv[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Stage 0: angle floored to Q.16, times 2/pi.
    logic                cmd0_reg;
    logic signed [31:0]  ang0_reg;
    logic signed [64:0]  qp0_reg;
    logic signed [31:0]  x16;
    assign x16 = s_angle >>> X16SH;

    // Stage 1: quadrant rounded to nearest, plus one for cosine.
    scp_pkg::q_t         q1_reg;
    logic signed [31:0]  ang1_reg;
    logic signed [64:0]  qsum;
    assign qsum = qp0_reg + Q_HALF;

    // Stage 2: quadrant times the pi/2 limbs; angle in Q.44 (mod 2^48).
    logic signed [43:0]  qhh2_reg;
    logic signed [42:0]  qhl2_reg;
    logic signed [47:0]  qlo2_reg;
    scp_pkg::red_t       x44_2_reg;
    logic [1:0]          qb2_reg;
    logic signed [63:0]  x44_full;
    assign x44_full = 64'(ang1_reg) <<< XSH;

    // Stage 3: reduced angle in Q.44. The exact value stays well within
    // 48 bits, so the subtraction runs modulo 2^48.
    scp_pkg::red_t       t44_3_reg;
    scp_pkg::red_t       lo_sum;
    scp_pkg::red_t       t44_next;
    assign lo_sum   = (qlo2_reg + LO_HALF) >>> 32;
    assign t44_next = x44_2_reg - (48'(qhh2_reg) << 24) - 48'(qhl2_reg) - lo_sum;

    // Stage 4 onward: polynomial datapath with the sideband alongside.
    scp_pkg::side_t      side_reg [3:13];
    scp_pkg::red_t       t_sum;
    assign t_sum = t44_3_reg + T_HALF;

    scp_pkg::prod_t      tt5_reg;
    scp_pkg::t_t         p6_reg;
    scp_pkg::prod_t      m7_reg;
    scp_pkg::t_t         p8_reg;
    scp_pkg::prod_t      m9_reg;
    scp_pkg::t_t         p10_reg;
    scp_pkg::prod_t      m11_reg;
    scp_pkg::t_t         p12_reg;
    scp_pkg::prod_t      m13_reg;
    scp_pkg::t_t         p13_reg;
    scp_pkg::t_t         pf14_reg;
    scp_pkg::t_t         pf_sel;
    assign pf_sel = side_reg[13].odd ? p13_reg : scp_pkg::rnd_q30(m13_reg);

    // Final rounding to the result format and saturation to +/-1.0.
    logic signed [34:0]  r_full;
    logic signed [34:0]  r_sat;
    assign r_full = (35'(pf14_reg) + RHALF) >>> RSH;

    always_comb begin
        r_sat = r_full;
        if (r_full > LIM) begin
            r_sat = LIM;
        end
        if (r_full < -LIM) begin
            r_sat = -LIM;
        end
    end

    // Payload registers: load on advance, no reset.
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            cmd0_reg <= s_cmd;
            ang0_reg <= s_angle;
            qp0_reg  <= 65'(x16) * scp_pkg::TWO_OVER_PI;
        end
        if (adv[1]) begin
            q1_reg   <= scp_pkg::q_t'(qsum >>> 48) + scp_pkg::q_t'(cmd0_reg);
            ang1_reg <= ang0_reg;
        end
        if (adv[2]) begin
            qhh2_reg  <= q1_reg * scp_pkg::PIO2_HI_H;
            qhl2_reg  <= q1_reg * scp_pkg::PIO2_HI_L;
            qlo2_reg  <= q1_reg * scp_pkg::PIO2_LO;
            x44_2_reg <= x44_full[47:0];
            qb2_reg   <= q1_reg[1:0];
        end
        if (adv[3]) begin
            t44_3_reg       <= t44_next;
            side_reg[3].odd <= qb2_reg[0];
            side_reg[3].neg <= qb2_reg[1];
            side_reg[3].t   <= '0;
            side_reg[3].t2  <= '0;
        end
        // Advance the sideband; stage 4 picks up t, stage 6 t squared.
        if (adv[4]) begin
            side_reg[4].odd <= side_reg[3].odd;
            side_reg[4].neg <= side_reg[3].neg;
            side_reg[4].t   <= scp_pkg::t_t'(t_sum >>> 14);
            side_reg[4].t2  <= side_reg[3].t2;
        end
        if (adv[5]) begin
            side_reg[5] <= side_reg[4];
            tt5_reg     <= side_reg[4].t * side_reg[4].t;
        end
        if (adv[6]) begin
            side_reg[6].odd <= side_reg[5].odd;
            side_reg[6].neg <= side_reg[5].neg;
            side_reg[6].t   <= side_reg[5].t;
            side_reg[6].t2  <= scp_pkg::rnd_q30(tt5_reg);
            p6_reg <= side_reg[5].odd ? scp_pkg::KC3 : scp_pkg::KS3;
        end
        for (int k = 7; k <= 13; k++) begin
            if (adv[k]) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
        // Horner: multiply, then round and add the next coefficient.
        if (adv[7]) begin
            m7_reg <= p6_reg * side_reg[6].t2;
        end
        if (adv[8]) begin
            p8_reg <= scp_pkg::rnd_q30(m7_reg)
                    + (side_reg[7].odd ? scp_pkg::KC2 : scp_pkg::KS2);
        end
        if (adv[9]) begin
            m9_reg <= p8_reg * side_reg[8].t2;
        end
        if (adv[10]) begin
            p10_reg <= scp_pkg::rnd_q30(m9_reg)
                     - (side_reg[9].odd ? scp_pkg::KC1 : scp_pkg::KS1);
        end
        if (adv[11]) begin
            m11_reg <= p10_reg * side_reg[10].t2;
        end
        if (adv[12]) begin
            p12_reg <= scp_pkg::rnd_q30(m11_reg)
                     + (side_reg[11].odd ? scp_pkg::KC0 : scp_pkg::KS0);
        end
        // Sine takes one more multiply by t; cosine passes p through.
        if (adv[13]) begin
            m13_reg <= p12_reg * side_reg[12].t;
            p13_reg <= p12_reg;
        end
        if (adv[14]) begin
            pf14_reg <= side_reg[13].neg ? -pf_sel : pf_sel;
        end
        if (adv[15]) begin
            m_value <= 32'(r_sat);
        end
    end

    // A ready output lets every stage advance, so the input is open too.
    a_ready_through: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output ready");

    // Reduction keeps |t| under 4 rad in Q.30.
    a_t_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[4] |-> (side_reg[4].t <= T_BOUND) && (side_reg[4].t >= -T_BOUND))
        else $error("reduced angle out of range");

    // Saturation keeps every result within +/-1.0.
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_value <= OUT_MAX) && (m_value >= -OUT_MAX))
        else $error("result beyond unit range");

    // An accepted request occupies the first stage on the next edge.
    a_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> valid_reg[0])
        else $error("accepted request lost at stage 0");

endmodule

`default_nettype wire
